>>> rtl/bmwm_pkg.sv
// ----------------------------------------------------------------------------
// bmwm_pkg: shared types and constants for the banked memory window mapper
// Holds the region codes, configuration register indexes, the configuration
// register bundle and the fixed sizes of the ROM and extended RAM population.
// ----------------------------------------------------------------------------
`default_nettype none

package bmwm_pkg;

  // Fitted sizes of the memory system
  localparam int ROM_SLOTS = 16;  // upper ROM slots that can be populated
  localparam int EXT_PAGES = 8;   // extended RAM pages that can be fitted

  localparam int ADDR_W   = 16;
  localparam int OFFSET_W = 14;
  localparam int BANK_W   = 8;
  localparam int REGION_W = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [REGION_W-1:0] {
    REG_MAIN   = 3'd0,
    REG_EXT    = 3'd1,
    REG_LOWER  = 3'd2,
    REG_UPPER  = 3'd3,
    REG_CART   = 3'd4,
    REG_EXPROM = 3'd5,
    REG_ASIC   = 3'd6
  } region_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BANK_SELECT  = 3'd0,
    CFG_ROM_CONTROL  = 3'd1,
    CFG_UPPER_ROM    = 3'd2,
    CFG_PAGING_MODE  = 3'd3,
    CFG_EXT_PRESENT  = 3'd4,
    CFG_ROM_PRESENT  = 3'd5
  } cfg_idx_e;

  // Configuration registers as one bundle
  typedef struct packed {
    logic [5:0]  bank_select;
    logic [5:0]  rom_control;
    logic [7:0]  upper_rom_select;
    logic [4:0]  paging_mode;
    logic [7:0]  ext_ram_present;
    logic [15:0] rom_present;
  } cfg_t;

  // Decoded mapping of one access
  typedef struct packed {
    region_e           region;
    logic [BANK_W-1:0] bank_index;
  } map_t;

endpackage : bmwm_pkg

`default_nettype wire

>>> rtl/bmwm_decode.sv
// ----------------------------------------------------------------------------
// bmwm_decode: window mapping of one processor access
// Combinational map from access kind and address to region and bank, given
// the current configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bmwm_decode (
  input  bmwm_pkg::cfg_t                   cfg_i,
  input  logic                             wr_i,
  input  logic [bmwm_pkg::ADDR_W-1:0]      addr_i,
  output bmwm_pkg::map_t                   map_o
);
  import bmwm_pkg::*;

  logic [1:0] win;
  logic [2:0] page_raw;
  logic [2:0] page;
  logic [1:0] bank;
  logic       single, lower_on, upper_on, romdis, ramdis, plus, exp_on;
  logic [1:0] pmode;
  logic [1:0] target;
  logic [7:0] num;
  logic       num_loaded;
  logic       keep_main;
  region_e    region;
  logic [BANK_W-1:0] idx;

  assign win      = addr_i[ADDR_W-1 -: 2];
  assign page_raw = cfg_i.bank_select[5:3];
  assign bank     = cfg_i.bank_select[1:0];
  assign single   = cfg_i.bank_select[2];
  assign lower_on = cfg_i.rom_control[0];
  assign upper_on = cfg_i.rom_control[1];
  assign romdis   = cfg_i.rom_control[2];
  assign ramdis   = cfg_i.rom_control[3];
  assign plus     = cfg_i.rom_control[4];
  assign exp_on   = cfg_i.rom_control[5];
  assign pmode    = cfg_i.paging_mode[4:3];
  assign target   = (pmode == 2'd3) ? 2'd0 : pmode;
  assign num      = cfg_i.upper_rom_select;

  // Fall back to page 0 for a page that is not fitted
  assign page = ((32'(page_raw) >= EXT_PAGES) || !cfg_i.ext_ram_present[page_raw])
                ? 3'd0 : page_raw;

  assign num_loaded = (num[7:4] == 4'd0) && (32'(num) < ROM_SLOTS) &&
                      cfg_i.rom_present[num[3:0]];

  assign keep_main = (win == 2'd0) && exp_on && (wr_i ? ramdis : (ramdis || romdis));

  always_comb begin
    region = REG_MAIN;
    idx    = {6'd0, win};

    // RAM banking, common to reads and writes
    if (single) begin
      if (win == 2'd1) begin
        region = REG_EXT;
        idx    = {3'd0, page, bank};
      end
    end else begin
      case (bank)
        2'd1: begin
          if (win == 2'd3) begin
            region = REG_EXT;
            idx    = {3'd0, page, 2'd3};
          end
        end
        2'd2: begin
          if (!keep_main) begin
            region = REG_EXT;
            idx    = {3'd0, page, win};
          end
        end
        2'd3: begin
          if (win == 2'd3) begin
            region = REG_EXT;
            idx    = {3'd0, page, 2'd3};
          end else if (win == 2'd1) begin
            region = REG_MAIN;
            idx    = 8'd3;
          end
        end
        default: ;
      endcase
    end

    if (wr_i) begin
      if ((win == 2'd0) && ramdis && exp_on) begin
        region = REG_EXPROM;
        idx    = '0;
      end
    end else begin
      if ((win == 2'd0) && romdis && exp_on) begin
        region = REG_EXPROM;
        idx    = '0;
      end
      if (lower_on) begin
        if (plus) begin
          if (win == target) begin
            region = REG_CART;
            idx    = {5'd0, cfg_i.paging_mode[2:0]};
          end
          if ((pmode == 2'd3) && (win == 2'd1)) begin
            region = REG_ASIC;
            idx    = '0;
          end
        end else if (win == 2'd0) begin
          region = REG_LOWER;
          idx    = '0;
        end
      end
      if (upper_on && (win == 2'd3)) begin
        if (plus) begin
          // Map logical ROM numbers onto cartridge banks, or onto a fitted upper ROM slot
          if (num[7]) begin
            region = REG_CART;
            idx    = {3'd0, num[4:0]};
          end else if (num == 8'd0) begin
            region = REG_CART;
            idx    = 8'd1;
          end else if (num == 8'd7) begin
            region = REG_CART;
            idx    = 8'd3;
          end else if (num_loaded) begin
            region = REG_UPPER;
            idx    = num;
          end else begin
            region = REG_CART;
            idx    = 8'd1;
          end
        end else begin
          region = REG_UPPER;
          idx    = num_loaded ? num : 8'd0;
        end
      end
    end
  end

  assign map_o.region     = region;
  assign map_o.bank_index = idx;

endmodule : bmwm_decode

`default_nettype wire

>>> rtl/banked_memory_window_mapper.sv
// ----------------------------------------------------------------------------
// banked_memory_window_mapper: four-window bank-switched memory mapper
// Maps each processor access onto a region, a bank and a 14-bit offset.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid_i/in_ready_o) carries one access per beat:
//    opcode_i (0 read, 1 write) and cpu_address_i.
//  - Output channel (out_valid_o/out_ready_i) returns one beat per access
//    with region_o, bank_index_o and offset_o, in order.
//  - Config channel (cfg_valid_i/cfg_ready_o) writes register cfg_index_i
//    with cfg_data_i; it is always ready. Indexes beyond the register list
//    are dropped. Write only while no access is in flight.
//  - An input beat waits in the input register, then passes through the
//    decode into the result register.
//  - Throughput is one access per cycle while results are taken, and
//    each stage holds a beat, so input stays ready while the result waits.
//  - When the receiver stalls, the result holds and the input register
//    fills; in_ready_o drops only once both stages are occupied.
//  - Reset empties both stages and loads the register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module banked_memory_window_mapper (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // access input
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                opcode_i,
  input  logic [bmwm_pkg::ADDR_W-1:0]         cpu_address_i,
  // mapping output
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [bmwm_pkg::REGION_W-1:0]       region_o,
  output logic [bmwm_pkg::BANK_W-1:0]         bank_index_o,
  output logic [bmwm_pkg::OFFSET_W-1:0]       offset_o,
  // configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bmwm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bmwm_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import bmwm_pkg::*;

  cfg_t  cfg_q;
  logic  s1_valid_q;
  logic  s1_wr_q;
  logic [ADDR_W-1:0] s1_addr_q;
  logic  out_valid_q;
  map_t  out_map_q;
  logic [OFFSET_W-1:0] out_offset_q;
  map_t  map;
  logic  advance;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bank_select      <= 6'd0;
      cfg_q.rom_control      <= 6'd3;
      cfg_q.upper_rom_select <= 8'd1;
      cfg_q.paging_mode      <= 5'd0;
      cfg_q.ext_ram_present  <= 8'd1;
      cfg_q.rom_present      <= 16'd0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_BANK_SELECT: cfg_q.bank_select      <= cfg_data_i[5:0];
        CFG_ROM_CONTROL: cfg_q.rom_control      <= cfg_data_i[5:0];
        CFG_UPPER_ROM:   cfg_q.upper_rom_select <= cfg_data_i[7:0];
        CFG_PAGING_MODE: cfg_q.paging_mode      <= cfg_data_i[4:0];
        CFG_EXT_PRESENT: cfg_q.ext_ram_present  <= cfg_data_i[7:0];
        CFG_ROM_PRESENT: cfg_q.rom_present      <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Advance the pipe whenever the result register is free or being taken
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_wr_q   <= opcode_i;
      s1_addr_q <= cpu_address_i;
    end
    if (advance && s1_valid_q) begin
      out_map_q    <= map;
      out_offset_q <= s1_addr_q[OFFSET_W-1:0];
    end
  end

  bmwm_decode u_decode (
    .cfg_i  (cfg_q),
    .wr_i   (s1_wr_q),
    .addr_i (s1_addr_q),
    .map_o  (map)
  );

  assign out_valid_o  = out_valid_q;
  assign region_o     = out_map_q.region;
  assign bank_index_o = out_map_q.bank_index;
  assign offset_o     = out_offset_q;

endmodule : banked_memory_window_mapper

`default_nettype wire

>>> rtl/bmwm_checker.sv
// ----------------------------------------------------------------------------
// bmwm_checker: port-level checks for the banked memory window mapper
// Watches the result channel for stall stability and legal mappings.
// ----------------------------------------------------------------------------
`default_nettype none

module bmwm_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                out_valid_o,
  input  logic                                out_ready_i,
  input  logic [bmwm_pkg::REGION_W-1:0]       region_o,
  input  logic [bmwm_pkg::BANK_W-1:0]         bank_index_o,
  input  logic [bmwm_pkg::OFFSET_W-1:0]       offset_o
);
  import bmwm_pkg::*;

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(region_o) && $stable(bank_index_o) && $stable(offset_o))
    else $error("result beat changed while stalled");

  a_region_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> region_o != 3'd7)
    else $error("illegal region code");

  a_zero_bank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (region_o == REG_LOWER || region_o == REG_EXPROM ||
                    region_o == REG_ASIC) |-> bank_index_o == '0)
    else $error("nonzero bank for single-bank region");

  a_main_bank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && region_o == REG_MAIN |-> bank_index_o[BANK_W-1:2] == '0)
    else $error("main RAM bank out of range");

  a_upper_bank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && region_o == REG_UPPER |-> bank_index_o[BANK_W-1:4] == '0)
    else $error("upper ROM number beyond slots");

endmodule : bmwm_checker

bind banked_memory_window_mapper bmwm_checker u_bmwm_checker (.*);

`default_nettype wire
